[rtl/hbd_pkg.sv]
// Shared types and constants for the HTTP body dechunker.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none

package hbd_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 32;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BODY_MODE   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BODY_LENGTH = 1'd1;

  // body mode codes
  localparam logic MODE_CHUNKED = 1'b0;
  localparam logic MODE_LENGTH  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_PAYLOAD  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COMPLETE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MALFORM  = 2'd2;

  // line end characters
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  // trailer bytes skipped after each chunk
  localparam logic [1:0] TRAILER_LEN = 2'd2;

  typedef struct packed {
    logic             body_mode;
    logic [LEN_W-1:0] body_length;
  } cfg_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // ascii hex character to nibble
  function automatic hex_t hex_decode(input logic [BYTE_W-1:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.val = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.val = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.val = 4'(b - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

[rtl/hbd_if.sv]
// Stream interfaces of the HTTP body dechunker: raw body bytes in, results out.
// Depends on hbd_pkg for field widths.
`default_nettype none

interface hbd_in_if;
  logic                       valid;
  logic                       ready;
  logic [hbd_pkg::BYTE_W-1:0] body_byte;

  modport source (output valid, output body_byte, input ready);
  modport sink   (input valid, input body_byte, output ready);
endinterface

interface hbd_out_if;
  logic                         valid;
  logic                         ready;
  logic [hbd_pkg::BYTE_W-1:0]   payload_byte;
  logic [hbd_pkg::STATUS_W-1:0] status;
  logic                         last;

  modport source (output valid, output payload_byte, output status, output last, input ready);
  modport sink   (input valid, input payload_byte, input status, input last, output ready);
endinterface

`default_nettype wire

[rtl/hbd_cfg_regs.sv]
// Configuration registers of the HTTP body dechunker (body mode, body length).
// Depends on hbd_pkg.
`default_nettype none

module hbd_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [hbd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [hbd_pkg::LEN_W-1:0]      cfg_wdata,
  output hbd_pkg::cfg_t                       cfg
);

  logic                       body_mode_r;
  logic [hbd_pkg::LEN_W-1:0]  body_length_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_mode_r   <= hbd_pkg::MODE_CHUNKED;
      body_length_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        hbd_pkg::CFG_BODY_MODE:   body_mode_r   <= cfg_wdata[0];
        hbd_pkg::CFG_BODY_LENGTH: body_length_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.body_mode   = body_mode_r;
  assign cfg.body_length = body_length_r;

endmodule

`default_nettype wire

[rtl/hbd_decode.sv]
// Body decoder: input byte register, chunk/length state machine, result register.
// Depends on hbd_pkg and the stream interfaces in hbd_if.sv.
`default_nettype none

module hbd_decode #(
  parameter int unsigned MAX_HEX_DIGITS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire hbd_pkg::cfg_t cfg,
  hbd_in_if.sink             in_ch,
  hbd_out_if.source          out_ch
);

  localparam int unsigned DCW = $clog2(MAX_HEX_DIGITS + 1);
  localparam int unsigned BW  = hbd_pkg::BYTE_W;
  localparam int unsigned LW  = hbd_pkg::LEN_W;

  typedef enum logic [2:0] {
    PH_START,
    PH_SIZE,
    PH_SIZE_CR,
    PH_DATA,
    PH_TRAIL,
    PH_LEN,
    PH_DONE
  } phase_t;

  // input register
  logic          in_vld_r;
  logic [BW-1:0] in_byte_r;

  // decoder state
  phase_t         phase_r,  phase_nxt;
  logic [LW-1:0]  size_r,   size_nxt;
  logic [DCW-1:0] dcnt_r,   dcnt_nxt;
  logic           bad_r,    bad_nxt;
  logic [LW-1:0]  left_r,   left_nxt;
  logic [1:0]     skip_r,   skip_nxt;

  // result register
  logic                         out_vld_r;
  logic [BW-1:0]                out_byte_r;
  logic [hbd_pkg::STATUS_W-1:0] out_status_r;
  logic                         out_last_r;

  // result of the byte in the input register
  logic                         res_vld;
  logic [BW-1:0]                res_byte;
  logic [hbd_pkg::STATUS_W-1:0] res_status;
  logic                         res_last;
  logic                         scan_en;
  hbd_pkg::hex_t                hx;
  logic                         fire;

  // next state for one body byte
  always_comb begin
    phase_nxt  = phase_r;
    size_nxt   = size_r;
    dcnt_nxt   = dcnt_r;
    bad_nxt    = bad_r;
    left_nxt   = left_r;
    skip_nxt   = skip_r;
    res_vld    = 1'b0;
    res_byte   = '0;
    res_status = hbd_pkg::ST_PAYLOAD;
    res_last   = 1'b0;
    scan_en    = 1'b0;
    hx         = hbd_pkg::hex_decode(in_byte_r);

    // first byte of the body picks the mode
    if (phase_r == PH_START) begin
      if (cfg.body_mode == hbd_pkg::MODE_LENGTH) begin
        if (cfg.body_length == '0) begin
          phase_nxt  = PH_DONE;
          res_vld    = 1'b1;
          res_status = hbd_pkg::ST_COMPLETE;
          res_last   = 1'b1;
        end else begin
          left_nxt  = cfg.body_length;
          phase_nxt = PH_LEN;
        end
      end else begin
        phase_nxt = PH_SIZE;
        size_nxt  = '0;
        dcnt_nxt  = '0;
        bad_nxt   = 1'b0;
      end
    end

    unique case (phase_nxt)
      PH_SIZE: begin
        if (in_byte_r == hbd_pkg::CHAR_CR) begin
          phase_nxt = PH_SIZE_CR;
        end else begin
          scan_en = 1'b1;
        end
      end
      PH_SIZE_CR: begin
        if (in_byte_r == hbd_pkg::CHAR_LF) begin
          // end of size line
          if (bad_nxt) begin
            phase_nxt  = PH_DONE;
            res_vld    = 1'b1;
            res_status = hbd_pkg::ST_MALFORM;
            res_last   = 1'b1;
          end else if (size_nxt == '0) begin
            phase_nxt  = PH_DONE;
            res_vld    = 1'b1;
            res_status = hbd_pkg::ST_COMPLETE;
            res_last   = 1'b1;
          end else begin
            left_nxt  = size_nxt;
            phase_nxt = PH_DATA;
          end
        end else begin
          // lone cr spoils the line
          bad_nxt = 1'b1;
          if (in_byte_r != hbd_pkg::CHAR_CR) begin
            scan_en   = 1'b1;
            phase_nxt = PH_SIZE;
          end
        end
      end
      PH_DATA: begin
        left_nxt = left_nxt - LW'(1);
        if (left_nxt == '0) begin
          phase_nxt = PH_TRAIL;
          skip_nxt  = hbd_pkg::TRAILER_LEN;
        end
        res_vld  = 1'b1;
        res_byte = in_byte_r;
      end
      PH_TRAIL: begin
        if (skip_nxt != 2'd0) begin
          skip_nxt = skip_nxt - 2'd1;
        end
        if (skip_nxt == 2'd0) begin
          phase_nxt = PH_SIZE;
          size_nxt  = '0;
          dcnt_nxt  = '0;
          bad_nxt   = 1'b0;
        end
      end
      PH_LEN: begin
        left_nxt = left_nxt - LW'(1);
        res_vld  = 1'b1;
        res_byte = in_byte_r;
        if (left_nxt == '0) begin
          phase_nxt = PH_DONE;
          res_last  = 1'b1;
        end
      end
      default: ;
    endcase

    // hex digit accumulation
    if (scan_en) begin
      if (!hx.ok) begin
        bad_nxt = 1'b1;
      end else if (dcnt_nxt < DCW'(MAX_HEX_DIGITS)) begin
        size_nxt = {size_nxt[LW-5:0], hx.val};
        dcnt_nxt = dcnt_nxt + DCW'(1);
      end else begin
        bad_nxt = 1'b1;
      end
    end
  end

  // the byte moves on unless it has a result and the result register is blocked
  assign fire         = in_vld_r && (!res_vld || !out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || fire;

  // input register, decoder state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      phase_r   <= PH_START;
      size_r    <= '0;
      dcnt_r    <= '0;
      bad_r     <= 1'b0;
      left_r    <= '0;
      skip_r    <= 2'd0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_vld_r  <= 1'b1;
        in_byte_r <= in_ch.body_byte;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end

      if (fire) begin
        phase_r <= phase_nxt;
        size_r  <= size_nxt;
        dcnt_r  <= dcnt_nxt;
        bad_r   <= bad_nxt;
        left_r  <= left_nxt;
        skip_r  <= skip_nxt;
      end

      if (fire && res_vld) begin
        out_vld_r    <= 1'b1;
        out_byte_r   <= res_byte;
        out_status_r <= res_status;
        out_last_r   <= res_last;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.payload_byte = out_byte_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.last         = out_last_r;

endmodule

`default_nettype wire

[rtl/http_body_dechunker.sv]
// HTTP body dechunker. Takes one body byte per cycle and gives at most one result per
// byte: a decoded payload byte, a completion, or a malformed-size-line end. Chunked
// mode parses hex size lines ended by CR LF, passes each chunk's bytes and skips the
// two bytes after them; length mode passes body_length bytes and marks the last. The
// mode is sampled on the first byte after reset and holds until the next reset; write
// configuration only while idle. Throughput is one byte per cycle when the output does
// not stall, set by the single state update between the input byte register and the
// result register, which a result passes through on its way to the output. Input
// ready drops only when the result register holds an untaken result and the pending
// byte would produce another.
// Depends on hbd_pkg, hbd_if, hbd_cfg_regs and hbd_decode.
`default_nettype none

module http_body_dechunker #(
  parameter int unsigned MAX_HEX_DIGITS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [hbd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [hbd_pkg::LEN_W-1:0]      cfg_wdata,
  hbd_in_if.sink                              in_ch,
  hbd_out_if.source                           out_ch
);

  hbd_pkg::cfg_t cfg;

  // configuration registers
  hbd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // decoder datapath
  hbd_decode #(
    .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
  ) u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

[rtl/hbd_checker.sv]
// Port-level checks for the HTTP body dechunker, bound to the top level.
// Depends on hbd_pkg and http_body_dechunker.
`default_nettype none

module hbd_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [hbd_pkg::BYTE_W-1:0]   out_payload_byte,
  input wire logic [hbd_pkg::STATUS_W-1:0] out_status,
  input wire logic                         out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_status) && $stable(out_last))
    else $error("result changed while stalled");

  // completion and malformed results end the body
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != hbd_pkg::ST_PAYLOAD |-> out_last)
    else $error("end status without last");

  // non-payload results carry a zero byte
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != hbd_pkg::ST_PAYLOAD |-> out_payload_byte == '0)
    else $error("end status with nonzero byte");

  // nothing follows the last result
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("result after end of body");

endmodule

bind http_body_dechunker hbd_checker u_hbd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_payload_byte (out_ch.payload_byte),
  .out_status       (out_ch.status),
  .out_last         (out_ch.last)
);

`default_nettype wire
